// ----- hw/rtl/fat_block_allocator_assert.svh -----
// assertion macros for the fat block allocator
// expects clk_i and rst_ni in the scope of each use
`ifndef FAT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FAT_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fat block allocator assertion failed");

// next-cycle implication, disabled during reset
`define FBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fat block allocator assertion failed");

`endif

// ----- hw/rtl/fba_pkg.sv -----
// shared constants, codes and controller/datapath structs
// no dependencies
package fba_pkg;

  localparam int FAT_BLOCKS_DEF  = 4096;
  localparam int BLOCK_BYTES_DEF = 512;
  localparam int DIR_ENTRIES_DEF = 16;

  localparam int OP_W    = 3;
  localparam int KEY_W   = 32;
  localparam int BYTES_W = 22;
  localparam int ST_W    = 3;
  localparam int BLK_W   = 12;
  localparam int CNT_W   = 13;
  localparam int SLOT_W  = 4;
  localparam int IN_W    = 96;
  localparam int OUT_W   = 32;

  localparam logic [BLK_W-1:0] END_MARK = 12'hFFF;

  localparam logic [OP_W-1:0] OP_NEW    = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_COPY   = 3'd2;
  localparam logic [OP_W-1:0] OP_RENAME = 3'd3;
  localparam logic [OP_W-1:0] OP_MODIFY = 3'd4;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_EXISTS   = 3'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [ST_W-1:0] ST_NOSPACE  = 3'd3;
  localparam logic [ST_W-1:0] ST_DIRFULL  = 3'd4;

  typedef struct packed {
    logic            start;
    logic            scan_step;
    logic            free_init;
    logic            free_rd;
    logic            free_wr;
    logic            take_init;
    logic            take_rd;
    logic            take_chk;
    logic            take_end;
    logic            commit;
    logic            set_err;
    logic [ST_W-1:0] err_code;
    logic            clear_step;
    logic            out_load;
  } fba_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             scan_last;
    logic             div_done;
    logic             s_found;
    logic             o_found;
    logic             f_found;
    logic             space_ok;
    logic             free_done;
    logic             take_done;
    logic             clear_last;
    logic             out_free;
    logic [CNT_W-1:0] free_cnt;
  } fba_stat_t;

endpackage

// ----- hw/rtl/fba_ctrl.sv -----
// command sequencer of the fat block allocator
// depends on fba_pkg
module fba_ctrl import fba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  fba_stat_t stat_i,
  output fba_cmd_t  cmd_o
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_SCAN     = 4'd2;
  localparam logic [3:0] S_DIV      = 4'd3;
  localparam logic [3:0] S_CHECK    = 4'd4;
  localparam logic [3:0] S_FREE_RD  = 4'd5;
  localparam logic [3:0] S_FREE_WR  = 4'd6;
  localparam logic [3:0] S_TAKE_RD  = 4'd7;
  localparam logic [3:0] S_TAKE_CHK = 4'd8;
  localparam logic [3:0] S_TAKE_END = 4'd9;
  localparam logic [3:0] S_COMMIT   = 4'd10;
  localparam logic [3:0] S_RESULT   = 4'd11;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) state_d = S_DIV;
      end
      S_DIV: begin
        if (stat_i.div_done) state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = S_RESULT;
        case (stat_i.op)
          OP_NEW: begin
            if (stat_i.s_found) begin
              cmd_o.set_err = 1'b1; cmd_o.err_code = ST_EXISTS;
            end else if (!stat_i.f_found) begin
              cmd_o.set_err = 1'b1; cmd_o.err_code = ST_DIRFULL;
            end else if (!stat_i.space_ok) begin
              cmd_o.set_err = 1'b1; cmd_o.err_code = ST_NOSPACE;
            end else begin
              cmd_o.take_init = 1'b1; state_d = S_TAKE_RD;
            end
          end
          OP_COPY: begin
            if (!stat_i.s_found) begin
              cmd_o.set_err = 1'b1; cmd_o.err_code = ST_NOTFOUND;
            end else if (stat_i.o_found) begin
              cmd_o.set_err = 1'b1; cmd_o.err_code = ST_EXISTS;
            end else if (!stat_i.f_found) begin
              cmd_o.set_err = 1'b1; cmd_o.err_code = ST_DIRFULL;
            end else if (!stat_i.space_ok) begin
              cmd_o.set_err = 1'b1; cmd_o.err_code = ST_NOSPACE;
            end else begin
              cmd_o.take_init = 1'b1; state_d = S_TAKE_RD;
            end
          end
          OP_DELETE: begin
            if (!stat_i.s_found) begin
              cmd_o.set_err = 1'b1; cmd_o.err_code = ST_NOTFOUND;
            end else begin
              cmd_o.free_init = 1'b1; state_d = S_FREE_RD;
            end
          end
          OP_RENAME: begin
            if (!stat_i.s_found) begin
              cmd_o.set_err = 1'b1; cmd_o.err_code = ST_NOTFOUND;
            end else if (stat_i.o_found) begin
              cmd_o.set_err = 1'b1; cmd_o.err_code = ST_EXISTS;
            end else begin
              state_d = S_COMMIT;
            end
          end
          OP_MODIFY: begin
            if (!stat_i.s_found) begin
              cmd_o.set_err = 1'b1; cmd_o.err_code = ST_NOTFOUND;
            end else if (!stat_i.space_ok) begin
              cmd_o.set_err = 1'b1; cmd_o.err_code = ST_NOSPACE;
            end else begin
              cmd_o.free_init = 1'b1; state_d = S_FREE_RD;
            end
          end
          default: state_d = S_COMMIT;
        endcase
      end
      S_FREE_RD: begin
        cmd_o.free_rd = 1'b1;
        if (!stat_i.free_done) begin
          state_d = S_FREE_WR;
        end else if (stat_i.op == OP_MODIFY) begin
          cmd_o.take_init = 1'b1;
          state_d         = S_TAKE_RD;
        end else begin
          state_d = S_COMMIT;
        end
      end
      S_FREE_WR: begin
        cmd_o.free_wr = 1'b1;
        state_d       = S_FREE_RD;
      end
      S_TAKE_RD: begin
        cmd_o.take_rd = 1'b1;
        state_d       = stat_i.take_done ? S_TAKE_END : S_TAKE_CHK;
      end
      S_TAKE_CHK: begin
        cmd_o.take_chk = 1'b1;
        state_d        = S_TAKE_RD;
      end
      S_TAKE_END: begin
        cmd_o.take_end = 1'b1;
        state_d        = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_RESULT;
      end
      S_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/fba_dp.sv -----
// datapath: fat memory, directory, size divider, chain walker, result registers
// depends on fba_pkg
module fba_dp import fba_pkg::*; #(
  parameter int FAT_BLOCKS  = FAT_BLOCKS_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int DIR_ENTRIES = DIR_ENTRIES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IN_W-1:0]  in_data_i,
  input  fba_cmd_t         cmd_i,
  output fba_stat_t        stat_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [OUT_W-1:0] out_data_o
);

  localparam int AW  = $clog2(FAT_BLOCKS);
  localparam int SW  = $clog2(DIR_ENTRIES);
  localparam int NW  = BYTES_W + 1;
  localparam int DCW = $clog2(NW + 1);
  localparam int MW  = BLK_W + 1;
  // reciprocal of the block size, exact for every NW-bit numerator
  localparam int DS  = NW + $clog2(BLOCK_BYTES);
  localparam int PW  = DS + NW;
  localparam logic [PW-1:0] RECIP =
    PW'(((64'd1 << DS) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES));

  // latched command
  logic [OP_W-1:0]    op_q;
  logic [KEY_W-1:0]   key_q, other_q;
  logic [BYTES_W-1:0] bytes_q;

  // directory
  logic [KEY_W-1:0]   dir_keys   [DIR_ENTRIES];
  logic [BYTES_W-1:0] dir_sizes  [DIR_ENTRIES];
  logic [BLK_W-1:0]   dir_starts [DIR_ENTRIES];
  logic [CNT_W-1:0]   dir_blocks [DIR_ENTRIES];
  logic [DIR_ENTRIES-1:0] dir_valid_q;

  // scan results
  logic [SW-1:0]      scan_q;
  logic               s_found_q, o_found_q, f_found_q;
  logic [SW-1:0]      s_slot_q, f_slot_q;
  logic [BYTES_W-1:0] s_size_q;
  logic [BLK_W-1:0]   s_start_q;
  logic [CNT_W-1:0]   s_blocks_q;

  // divider
  logic [NW-1:0]  num_q, quo_q;
  logic [PW-1:0]  prod;
  logic [DCW-1:0] dcnt_q;

  // fat memory and walker
  logic [MW-1:0]    fat_mem [FAT_BLOCKS];
  logic [MW-1:0]    rdata_q, mem_wd;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_wa, mem_ra, clr_q;
  logic [BLK_W-1:0] wb_q, prev_q, first_q;
  logic [CNT_W-1:0] walk_q, got_q, need_q, free_q;

  // space check
  logic [NW-1:0]    need_sel, avail;
  logic [CNT_W-1:0] need_cnt;

  // result and output
  logic [ST_W-1:0]   res_st_q;
  logic [BLK_W-1:0]  res_start_q;
  logic [CNT_W-1:0]  res_cnt_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic              out_valid_q;
  logic [OUT_W-1:0]  out_q;
  logic [SW+SLOT_W-1:0] s_slot_w, f_slot_w;

  assign s_slot_w = {{SLOT_W{1'b0}}, s_slot_q};
  assign f_slot_w = {{SLOT_W{1'b0}}, f_slot_q};

  // size to block count: reciprocal multiply of num_q, registered into quo_q after start
  assign prod = PW'(num_q) * RECIP;

  assign need_sel = (op_q == OP_COPY) ? NW'(s_blocks_q) : quo_q;
  assign avail    = NW'(free_q) + ((op_q == OP_MODIFY) ? NW'(s_blocks_q) : NW'(0));
  assign need_cnt = need_sel[CNT_W-1:0];

  assign stat_o.op         = op_q;
  assign stat_o.scan_last  = (scan_q == SW'(DIR_ENTRIES - 1));
  assign stat_o.div_done   = (dcnt_q == '0);
  assign stat_o.s_found    = s_found_q;
  assign stat_o.o_found    = o_found_q;
  assign stat_o.f_found    = f_found_q;
  assign stat_o.space_ok   = (need_sel <= avail);
  assign stat_o.free_done  = (walk_q == '0);
  assign stat_o.take_done  = (got_q == need_q);
  assign stat_o.clear_last = (clr_q == AW'(FAT_BLOCKS - 1));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  assign stat_o.free_cnt   = free_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // memory port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = wb_q[AW-1:0];
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = wb_q[AW-1:0];
    if (cmd_i.clear_step) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
      mem_wd = (clr_q == '0) ? {1'b1, END_MARK} : '0;
    end
    if (cmd_i.free_wr) begin
      mem_we = 1'b1;
    end
    if (cmd_i.take_chk && !rdata_q[BLK_W] && (got_q != '0)) begin
      mem_we = 1'b1;
      mem_wa = prev_q[AW-1:0];
      mem_wd = {1'b1, wb_q};
    end
    if (cmd_i.take_end && (got_q != '0)) begin
      mem_we = 1'b1;
      mem_wa = prev_q[AW-1:0];
      mem_wd = {1'b1, END_MARK};
    end
    if ((cmd_i.free_rd && (walk_q != '0)) || (cmd_i.take_rd && (got_q != need_q))) begin
      mem_re = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) fat_mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_q <= fat_mem[mem_ra];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      dir_valid_q <= '0;
      free_q      <= CNT_W'(FAT_BLOCKS - 1);
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_step) clr_q <= clr_q + AW'(1);
      if (cmd_i.start) begin
        dcnt_q <= DCW'(1);
      end else if (dcnt_q != '0) begin
        dcnt_q <= dcnt_q - DCW'(1);
      end
      if (cmd_i.free_wr) free_q <= free_q + CNT_W'(1);
      if (cmd_i.take_end) free_q <= free_q - got_q;
      if (cmd_i.commit) begin
        case (op_q)
          OP_NEW, OP_COPY: dir_valid_q[f_slot_q] <= 1'b1;
          OP_DELETE:       dir_valid_q[s_slot_q] <= 1'b0;
          default: ;
        endcase
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q      <= in_data_i[2:0];
      key_q     <= in_data_i[34:3];
      other_q   <= in_data_i[66:35];
      bytes_q   <= in_data_i[88:67];
      scan_q    <= '0;
      s_found_q <= 1'b0;
      o_found_q <= 1'b0;
      f_found_q <= 1'b0;
      num_q     <= NW'(in_data_i[88:67]) + NW'(BLOCK_BYTES - 1);
      quo_q     <= '0;
    end else if (dcnt_q != '0) begin
      quo_q <= prod[DS +: NW];
    end

    if (cmd_i.scan_step) begin
      scan_q <= scan_q + SW'(1);
      if (dir_valid_q[scan_q] && (dir_keys[scan_q] == key_q) && !s_found_q) begin
        s_found_q  <= 1'b1;
        s_slot_q   <= scan_q;
        s_size_q   <= dir_sizes[scan_q];
        s_start_q  <= dir_starts[scan_q];
        s_blocks_q <= dir_blocks[scan_q];
      end
      if (dir_valid_q[scan_q] && (dir_keys[scan_q] == other_q)) o_found_q <= 1'b1;
      if (!dir_valid_q[scan_q] && !f_found_q) begin
        f_found_q <= 1'b1;
        f_slot_q  <= scan_q;
      end
    end

    // chain walks
    if (cmd_i.free_init) begin
      wb_q   <= s_start_q;
      walk_q <= s_blocks_q;
    end
    if (cmd_i.free_wr) begin
      wb_q   <= rdata_q[BLK_W-1:0];
      walk_q <= walk_q - CNT_W'(1);
    end
    if (cmd_i.take_init) begin
      wb_q    <= BLK_W'(1);
      got_q   <= '0;
      need_q  <= need_cnt;
      first_q <= '0;
    end
    if (cmd_i.take_chk) begin
      wb_q <= wb_q + BLK_W'(1);
      if (!rdata_q[BLK_W]) begin
        prev_q <= wb_q;
        got_q  <= got_q + CNT_W'(1);
        if (got_q == '0) first_q <= wb_q;
      end
    end

    // directory update and result
    if (cmd_i.set_err) begin
      res_st_q    <= cmd_i.err_code;
      res_start_q <= '0;
      res_cnt_q   <= '0;
      res_slot_q  <= '0;
    end
    if (cmd_i.commit) begin
      res_st_q    <= ST_OK;
      res_start_q <= '0;
      res_cnt_q   <= '0;
      res_slot_q  <= '0;
      case (op_q)
        OP_NEW: begin
          dir_keys[f_slot_q]   <= key_q;
          dir_sizes[f_slot_q]  <= bytes_q;
          dir_starts[f_slot_q] <= first_q;
          dir_blocks[f_slot_q] <= need_q;
          res_start_q <= first_q;
          res_cnt_q   <= need_q;
          res_slot_q  <= f_slot_w[SLOT_W-1:0];
        end
        OP_COPY: begin
          dir_keys[f_slot_q]   <= other_q;
          dir_sizes[f_slot_q]  <= s_size_q;
          dir_starts[f_slot_q] <= first_q;
          dir_blocks[f_slot_q] <= need_q;
          res_start_q <= first_q;
          res_cnt_q   <= need_q;
          res_slot_q  <= f_slot_w[SLOT_W-1:0];
        end
        OP_DELETE: begin
          res_slot_q <= s_slot_w[SLOT_W-1:0];
        end
        OP_RENAME: begin
          dir_keys[s_slot_q] <= other_q;
          res_start_q <= s_start_q;
          res_cnt_q   <= s_blocks_q;
          res_slot_q  <= s_slot_w[SLOT_W-1:0];
        end
        OP_MODIFY: begin
          dir_sizes[s_slot_q]  <= bytes_q;
          dir_starts[s_slot_q] <= first_q;
          dir_blocks[s_slot_q] <= need_q;
          res_start_q <= first_q;
          res_cnt_q   <= need_q;
          res_slot_q  <= s_slot_w[SLOT_W-1:0];
        end
        default: ;
      endcase
    end

    if (cmd_i.out_load) out_q <= {res_slot_q, res_cnt_q, res_start_q, res_st_q};
  end

endmodule

// ----- hw/rtl/fat_block_allocator.sv -----
// fat block allocator top level: stream ports, sequencer and datapath
// depends on fba_pkg, fba_ctrl, fba_dp and fat_block_allocator_assert.svh
//
// usage
// - one command per slave-side transfer, one result per command on the master side
// - a command is taken only while the block is idle; the previous result may still
//   wait in the output register, and the slave side stays open meanwhile
// - per command: the accepting state, a scan of all DIR_ENTRIES directory entries
//   (the block count multiply finishes inside it), a wait state and a decision
//   state; delete and modify then free the old chain in read and write steps, and new,
//   copy and modify walk the fat entries in read and check steps while taking blocks
//   and then end the new chain; a commit and the load into the output register close
//   it, errors skip the commit
// - the fat memory is walked one entry at a time, read then check or write
// - after reset a clearing pass writes all FAT_BLOCKS fat entries, one per cycle;
//   no command is taken during the pass
// - a stalled master side holds the result; the next command finishes up to its
//   result stage and waits there until the output register is free
// - unknown operations answer ok with zero fields and change nothing
`include "fat_block_allocator_assert.svh"

module fat_block_allocator import fba_pkg::*; #(
  parameter int FAT_BLOCKS  = FAT_BLOCKS_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int DIR_ENTRIES = DIR_ENTRIES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // operation[2:0], file_key[34:3], other_key[66:35], file_bytes[88:67], zero fill
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // status[2:0], start_block[14:3], block_count[27:15], slot_index[31:28]
  output logic [OUT_W-1:0] m_axis_tdata
);

  fba_cmd_t  cmd;
  fba_stat_t stat;

  // sequencer: owns the command flow and the slave-side ready
  fba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: directory, fat memory, divider and the output register
  fba_dp #(
    .FAT_BLOCKS  (FAT_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .DIR_ENTRIES (DIR_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

  // the block goes busy right after taking a command
  `FBA_ASSERT_NEXT(a_busy_after_transfer, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // free count never exceeds the allocatable blocks
  `FBA_ASSERT_NOW(a_free_range, 1'b1, stat.free_cnt <= CNT_W'(FAT_BLOCKS - 1))
  // a result is only loaded when the output register can take it
  `FBA_ASSERT_NOW(a_load_when_free, cmd.out_load, stat.out_free)

endmodule
